### rtl/s2c_pkg.sv
`timescale 1ns / 1ps

package s2c_pkg;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 3;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_ELEVATION_MODE       = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_ZERO_AZIMUTH_AXIS    = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_QUARTER_AZIMUTH_AXIS = 2'd2;

	localparam logic [1:0] ELEV_FROM_NORMAL     = 2'd0;
	localparam logic [1:0] ELEV_FROM_NEG_NORMAL = 2'd1;
	localparam logic [1:0] ELEV_FROM_PLANE      = 2'd2;

	localparam logic [2:0] AXIS_POS_X = 3'd0;
	localparam logic [2:0] AXIS_POS_Y = 3'd1;
	localparam logic [2:0] AXIS_POS_Z = 3'd2;
	localparam logic [2:0] AXIS_NEG_X = 3'd3;
	localparam logic [2:0] AXIS_NEG_Y = 3'd4;
	localparam logic [2:0] AXIS_NEG_Z = 3'd5;

	// Odd Taylor coefficients of sin(pi/2 * u) in Q1.30.
	localparam logic [30:0] K1  = 31'd1686629713;
	localparam logic [30:0] K3  = 31'd693598668;
	localparam logic [30:0] K5  = 31'd85569306;
	localparam logic [30:0] K7  = 31'd5026995;
	localparam logic [30:0] K9  = 31'd172272;
	localparam logic [30:0] K11 = 31'd3864;

	localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
	localparam logic [30:0] HALF_Q30 = 31'h2000_0000;

	typedef struct packed {
		logic [29:0] u;
		logic        full;
	} phase_t;

	typedef struct packed {
		logic [30:0] mag;
		logic        neg;
	} trig_t;

	typedef struct packed {
		logic en;
		logic neg;
	} axis_coef_t;

endpackage

### rtl/spherical_to_cartesian_point.sv
`timescale 1ns / 1ps

// Converts scanner points given as range, azimuth and elevation into x, y and z.
// A request on the point channel carries range_value, azimuth_angle and
// elevation_angle; it is taken at a clock edge where point_valid is high and
// point_stall is low. Each request yields one request on the coordinate channel
// with pos_x, pos_y and pos_z, taken where coord_valid is high and coord_stall low.
// The datapath is a twelve-stage pipeline that sustains one point per cycle while
// coord_stall is low. The four polynomial sine evaluations occupy stages s2 to
// s8, one multiply per stage. When the receiver stalls, the final stage holds
// its result and earlier stages keep filling until every stage is occupied;
// only then is point_stall raised. Configuration is written through cfg_we,
// cfg_index and cfg_data; the user must do so only while the pipeline is empty,
// which the block itself does not enforce. Reset empties the pipeline and restores
// elevation from the normal, azimuth zero on +X and azimuth ninety on +Y.

module spherical_to_cartesian_point
	import s2c_pkg::*;
#(
	parameter int RANGE_BITS = 24,
	parameter int ANGLE_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [CFG_INDEX_BITS-1:0]        cfg_index,
	input  logic [CFG_DATA_BITS-1:0]         cfg_data,
	input  logic                             point_valid,
	output logic                             point_stall,
	input  logic [RANGE_BITS-1:0]            range_value,
	input  logic [ANGLE_BITS-1:0]            azimuth_angle,
	input  logic [ANGLE_BITS-1:0]            elevation_angle,
	output logic                             coord_valid,
	input  logic                             coord_stall,
	output logic signed [RANGE_BITS:0]       pos_x,
	output logic signed [RANGE_BITS:0]       pos_y,
	output logic signed [RANGE_BITS:0]       pos_z
);

	localparam int NUM_STAGES  = 12;
	localparam int PB          = ANGLE_BITS - 2;
	localparam int PHASE_SHIFT = 32 - ANGLE_BITS;
	localparam int MW          = RANGE_BITS + 31;
	localparam int SW          = RANGE_BITS + 3;
	localparam logic signed [SW-1:0] SAT_HI = SW'((64'd1 << RANGE_BITS) - 64'd1);
	localparam logic signed [SW-1:0] SAT_LO = -SAT_HI;

	typedef struct packed {
		logic [RANGE_BITS-1:0] rng;
		logic [1:0]            quad_az;
		logic [1:0]            quad_el;
	} side_t;

	function automatic phase_t to_phase(input logic [PB-1:0] p, input logic comp);
		logic [PB-1:0] pv;
		phase_t        r;
		pv     = comp ? PB'(~p + PB'(1)) : p;
		r.u    = 30'(pv) << PHASE_SHIFT;
		r.full = comp && (p == '0);
		return r;
	endfunction

	function automatic logic [29:0] square_q30(input logic [29:0] u);
		logic [59:0] p;
		p = 60'(u) * 60'(u);
		return p[59:30];
	endfunction

	function automatic logic [30:0] horner(input logic [29:0] u2, input logic [30:0] t,
			input logic [30:0] k);
		logic [60:0] p;
		p = 61'(u2) * 61'(t);
		return k - p[60:30];
	endfunction

	function automatic logic [30:0] final_sine(input phase_t ph, input logic [30:0] t);
		logic [60:0] p;
		logic [30:0] q;
		p = 61'(ph.u) * 61'(t);
		q = p[60:30];
		if (ph.full || q > ONE_Q30) begin
			return ONE_Q30;
		end
		return q;
	endfunction

	function automatic logic [RANGE_BITS-1:0] round_mul(input logic [RANGE_BITS-1:0] a,
			input logic [30:0] b);
		logic [MW-1:0] p;
		p = MW'(a) * MW'(b) + MW'(HALF_Q30);
		return p[RANGE_BITS+29:30];
	endfunction

	function automatic logic signed [RANGE_BITS:0] to_signed(input logic [RANGE_BITS-1:0] mag,
			input logic neg);
		logic signed [RANGE_BITS:0] v;
		v = $signed({1'b0, mag});
		return neg ? -v : v;
	endfunction

	function automatic axis_coef_t axis_of(input logic [2:0] code, input logic [1:0] k);
		axis_coef_t c;
		logic [1:0] idx;
		c   = '0;
		idx = 2'd0;
		case (code)
			AXIS_POS_X: begin c = '{en: 1'b1, neg: 1'b0}; idx = 2'd0; end
			AXIS_POS_Y: begin c = '{en: 1'b1, neg: 1'b0}; idx = 2'd1; end
			AXIS_POS_Z: begin c = '{en: 1'b1, neg: 1'b0}; idx = 2'd2; end
			AXIS_NEG_X: begin c = '{en: 1'b1, neg: 1'b1}; idx = 2'd0; end
			AXIS_NEG_Y: begin c = '{en: 1'b1, neg: 1'b1}; idx = 2'd1; end
			AXIS_NEG_Z: begin c = '{en: 1'b1, neg: 1'b1}; idx = 2'd2; end
			default:    c = '0;
		endcase
		if (idx != k) begin
			c = '0;
		end
		return c;
	endfunction

	// At most one of the two cross-product terms can be non-zero for unit axes.
	function automatic axis_coef_t cross_of(input logic [2:0] c0, input logic [2:0] c1,
			input logic [1:0] k);
		logic [1:0] k1;
		logic [1:0] k2;
		axis_coef_t a0k1, a0k2, a1k1, a1k2, n;
		logic       t1en, t1neg, t2en, t2neg;
		case (k)
			2'd0:    begin k1 = 2'd1; k2 = 2'd2; end
			2'd1:    begin k1 = 2'd2; k2 = 2'd0; end
			default: begin k1 = 2'd0; k2 = 2'd1; end
		endcase
		a0k1  = axis_of(c0, k1);
		a0k2  = axis_of(c0, k2);
		a1k1  = axis_of(c1, k1);
		a1k2  = axis_of(c1, k2);
		t1en  = a0k1.en & a1k2.en;
		t1neg = a0k1.neg ^ a1k2.neg;
		t2en  = a0k2.en & a1k1.en;
		t2neg = !(a0k2.neg ^ a1k1.neg);
		n.en  = t1en | t2en;
		n.neg = t1en ? t1neg : t2neg;
		return n;
	endfunction

	function automatic logic signed [SW-1:0] apply_coef(input axis_coef_t c,
			input logic signed [RANGE_BITS:0] v);
		logic signed [SW-1:0] ext;
		ext = $signed({{2{v[RANGE_BITS]}}, v});
		if (!c.en) begin
			return '0;
		end
		return c.neg ? -ext : ext;
	endfunction

	logic [1:0] elevation_mode_q;
	logic [2:0] zero_azimuth_axis_q;
	logic [2:0] quarter_azimuth_axis_q;

	logic [NUM_STAGES:1] valid_q;
	logic [NUM_STAGES:1] stage_ready;

	side_t  side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7, side_s8;
	phase_t ph_s1 [4];
	phase_t ph_s2 [4];
	phase_t ph_s3 [4];
	phase_t ph_s4 [4];
	phase_t ph_s5 [4];
	phase_t ph_s6 [4];
	phase_t ph_s7 [4];
	logic [29:0] u2_s2 [4];
	logic [29:0] u2_s3 [4];
	logic [29:0] u2_s4 [4];
	logic [29:0] u2_s5 [4];
	logic [29:0] u2_s6 [4];
	logic [30:0] t_s3 [4];
	logic [30:0] t_s4 [4];
	logic [30:0] t_s5 [4];
	logic [30:0] t_s6 [4];
	logic [30:0] t_s7 [4];
	logic [30:0] sine_s8 [4];

	logic [RANGE_BITS-1:0] range_s9;
	trig_t sa_s9, ca_s9, ln_trig_s9, le_trig_s9;
	trig_t sa_s10, ca_s10;
	logic [RANGE_BITS-1:0] ln_mag_s10, le_mag_s10;
	logic ln_neg_s10, le_neg_s10;
	logic signed [RANGE_BITS:0] ta_s11, tb_s11, ln_s11;
	logic signed [RANGE_BITS:0] pos_s12 [3];

	phase_t ph_in [4];
	trig_t  sa_next, ca_next, se_next, ce_next, ln_trig_next, le_trig_next;
	logic signed [RANGE_BITS:0] pos_next [3];

	always_comb begin
		stage_ready[NUM_STAGES] = !valid_q[NUM_STAGES] || !coord_stall;
		for (int k = NUM_STAGES - 1; k >= 1; k--) begin
			stage_ready[k] = !valid_q[k] || stage_ready[k+1];
		end
	end

	assign point_stall = !stage_ready[1];
	assign coord_valid = valid_q[NUM_STAGES];
	assign pos_x       = pos_s12[0];
	assign pos_y       = pos_s12[1];
	assign pos_z       = pos_s12[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q                <= '0;
			elevation_mode_q       <= ELEV_FROM_NORMAL;
			zero_azimuth_axis_q    <= AXIS_POS_X;
			quarter_azimuth_axis_q <= AXIS_POS_Y;
		end else begin
			if (stage_ready[1]) begin
				valid_q[1] <= point_valid;
			end
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (stage_ready[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_ELEVATION_MODE:       elevation_mode_q       <= cfg_data[1:0];
					CFG_ZERO_AZIMUTH_AXIS:    zero_azimuth_axis_q    <= cfg_data;
					CFG_QUARTER_AZIMUTH_AXIS: quarter_azimuth_axis_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Lanes 0 and 1 give sine and cosine of the azimuth phase, lanes 2 and 3 of
	// the elevation phase.
	always_comb begin
		ph_in[0] = to_phase(azimuth_angle[PB-1:0], 1'b0);
		ph_in[1] = to_phase(azimuth_angle[PB-1:0], 1'b1);
		ph_in[2] = to_phase(elevation_angle[PB-1:0], 1'b0);
		ph_in[3] = to_phase(elevation_angle[PB-1:0], 1'b1);
	end

	always_ff @(posedge clk) begin
		if (stage_ready[1]) begin
			side_s1.rng     <= range_value;
			side_s1.quad_az <= azimuth_angle[ANGLE_BITS-1 -: 2];
			side_s1.quad_el <= elevation_angle[ANGLE_BITS-1 -: 2];
			for (int l = 0; l < 4; l++) begin
				ph_s1[l] <= ph_in[l];
			end
		end
		if (stage_ready[2]) begin
			side_s2 <= side_s1;
			for (int l = 0; l < 4; l++) begin
				ph_s2[l] <= ph_s1[l];
				u2_s2[l] <= square_q30(ph_s1[l].u);
			end
		end
		if (stage_ready[3]) begin
			side_s3 <= side_s2;
			for (int l = 0; l < 4; l++) begin
				ph_s3[l] <= ph_s2[l];
				u2_s3[l] <= u2_s2[l];
				t_s3[l]  <= horner(u2_s2[l], K11, K9);
			end
		end
		if (stage_ready[4]) begin
			side_s4 <= side_s3;
			for (int l = 0; l < 4; l++) begin
				ph_s4[l] <= ph_s3[l];
				u2_s4[l] <= u2_s3[l];
				t_s4[l]  <= horner(u2_s3[l], t_s3[l], K7);
			end
		end
		if (stage_ready[5]) begin
			side_s5 <= side_s4;
			for (int l = 0; l < 4; l++) begin
				ph_s5[l] <= ph_s4[l];
				u2_s5[l] <= u2_s4[l];
				t_s5[l]  <= horner(u2_s4[l], t_s4[l], K5);
			end
		end
		if (stage_ready[6]) begin
			side_s6 <= side_s5;
			for (int l = 0; l < 4; l++) begin
				ph_s6[l] <= ph_s5[l];
				u2_s6[l] <= u2_s5[l];
				t_s6[l]  <= horner(u2_s5[l], t_s5[l], K3);
			end
		end
		if (stage_ready[7]) begin
			side_s7 <= side_s6;
			for (int l = 0; l < 4; l++) begin
				ph_s7[l] <= ph_s6[l];
				t_s7[l]  <= horner(u2_s6[l], t_s6[l], K1);
			end
		end
		if (stage_ready[8]) begin
			side_s8 <= side_s7;
			for (int l = 0; l < 4; l++) begin
				sine_s8[l] <= final_sine(ph_s7[l], t_s7[l]);
			end
		end
	end

	// The quadrant maps the first-quadrant pair onto the signed sine and cosine.
	always_comb begin
		sa_next.mag = side_s8.quad_az[0] ? sine_s8[1] : sine_s8[0];
		sa_next.neg = side_s8.quad_az[1];
		ca_next.mag = side_s8.quad_az[0] ? sine_s8[0] : sine_s8[1];
		ca_next.neg = side_s8.quad_az[1] ^ side_s8.quad_az[0];
		se_next.mag = side_s8.quad_el[0] ? sine_s8[3] : sine_s8[2];
		se_next.neg = side_s8.quad_el[1];
		ce_next.mag = side_s8.quad_el[0] ? sine_s8[2] : sine_s8[3];
		ce_next.neg = side_s8.quad_el[1] ^ side_s8.quad_el[0];
		case (elevation_mode_q)
			ELEV_FROM_NORMAL: begin
				ln_trig_next = ce_next;
				le_trig_next = se_next;
			end
			ELEV_FROM_NEG_NORMAL: begin
				ln_trig_next = '{mag: ce_next.mag, neg: !ce_next.neg};
				le_trig_next = se_next;
			end
			ELEV_FROM_PLANE: begin
				ln_trig_next = se_next;
				le_trig_next = ce_next;
			end
			default: begin
				ln_trig_next = '0;
				le_trig_next = '0;
			end
		endcase
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic signed [SW-1:0] sum;
			sum = apply_coef(axis_of(zero_azimuth_axis_q, 2'(k)), ta_s11)
				+ apply_coef(axis_of(quarter_azimuth_axis_q, 2'(k)), tb_s11)
				+ apply_coef(cross_of(zero_azimuth_axis_q, quarter_azimuth_axis_q, 2'(k)),
					ln_s11);
			if (sum > SAT_HI) begin
				sum = SAT_HI;
			end else if (sum < SAT_LO) begin
				sum = SAT_LO;
			end
			pos_next[k] = sum[RANGE_BITS:0];
		end
	end

	always_ff @(posedge clk) begin
		if (stage_ready[9]) begin
			range_s9   <= side_s8.rng;
			sa_s9      <= sa_next;
			ca_s9      <= ca_next;
			ln_trig_s9 <= ln_trig_next;
			le_trig_s9 <= le_trig_next;
		end
		if (stage_ready[10]) begin
			sa_s10     <= sa_s9;
			ca_s10     <= ca_s9;
			ln_mag_s10 <= round_mul(range_s9, ln_trig_s9.mag);
			ln_neg_s10 <= ln_trig_s9.neg;
			le_mag_s10 <= round_mul(range_s9, le_trig_s9.mag);
			le_neg_s10 <= le_trig_s9.neg;
		end
		if (stage_ready[11]) begin
			ta_s11 <= to_signed(round_mul(le_mag_s10, ca_s10.mag), le_neg_s10 ^ ca_s10.neg);
			tb_s11 <= to_signed(round_mul(le_mag_s10, sa_s10.mag), le_neg_s10 ^ sa_s10.neg);
			ln_s11 <= to_signed(ln_mag_s10, ln_neg_s10);
		end
		if (stage_ready[12]) begin
			for (int k = 0; k < 3; k++) begin
				pos_s12[k] <= pos_next[k];
			end
		end
	end

endmodule
